FILE: rtl/core/kswstat_pkg.sv
package kswstat_pkg;

   localparam int unsigned MAX_WINDOW = 32;
   localparam int unsigned COUNT_W = 32;
   localparam int unsigned TOTAL_W = 37;
   localparam int unsigned LEN_W = 6;

   typedef struct packed {
      logic [COUNT_W-1:0] kmer_count;
      logic               seq_start;
      logic               seq_end;
   } req_item_type;

   typedef struct packed {
      logic [COUNT_W-1:0] count_here;
      logic [LEN_W-1:0]   depth;
      logic [COUNT_W-1:0] min_count;
      logic [COUNT_W-1:0] max_count;
      logic [TOTAL_W-1:0] total_count;
      logic               last_of_sequence;
   } stat_item_type;

endpackage

FILE: rtl/core/kswstat_front.sv
module kswstat_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  kswstat_pkg::req_item_type  in_item,
   input  logic [5:0]                 window_length,
   output logic                       out_valid,
   input  logic                       out_ready,
   output kswstat_pkg::stat_item_type out_item
);
   import kswstat_pkg::*;

   localparam int IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int POS_W = $clog2(MAX_WINDOW + 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [COUNT_W-1:0] window_ff [MAX_WINDOW];
   logic [1:0]         state_ff, state_in;
   logic [POS_W-1:0]   pos_ff;
   logic [POS_W-1:0]   len_ff;
   stat_item_type      acc_ff;
   logic [COUNT_W-1:0] cur;
   logic [6:0]         len_lim;
   logic               take;

   assign in_ready  = (state_ff == ST_IDLE);
   assign out_valid = (state_ff == ST_DONE);
   assign take      = in_valid && in_ready;
   assign cur       = window_ff[pos_ff[IDX_W-1:0]];

   always_comb begin
      len_lim = {1'b0, window_length};
      if (len_lim == 7'd0) len_lim = 7'd1;
      if (len_lim > 7'(MAX_WINDOW)) len_lim = 7'(MAX_WINDOW);
   end

   always_comb begin
      out_item = acc_ff;
      if (acc_ff.depth == '0) begin
         out_item.min_count = '0;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (take) state_in = ST_SCAN;
         ST_SCAN: if (pos_ff == len_ff - POS_W'(1)) state_in = ST_DONE;
         ST_DONE: if (out_ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         for (int i = 0; i < MAX_WINDOW; i++) window_ff[i] <= '0;
      end else begin
         state_ff <= state_in;
         if (take) begin
            for (int i = MAX_WINDOW - 1; i > 0; i--) begin
               window_ff[i] <= in_item.seq_start ? '0 : window_ff[i-1];
            end
            window_ff[0] <= in_item.kmer_count;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         pos_ff                   <= '0;
         len_ff                   <= POS_W'(len_lim);
         acc_ff.count_here        <= in_item.kmer_count;
         acc_ff.last_of_sequence  <= in_item.seq_end;
         acc_ff.depth             <= '0;
         acc_ff.min_count         <= '1;
         acc_ff.max_count         <= '0;
         acc_ff.total_count       <= '0;
      end else if (state_ff == ST_SCAN) begin
         pos_ff <= pos_ff + POS_W'(1);
         if (cur != '0) begin
            acc_ff.depth       <= acc_ff.depth + LEN_W'(1);
            acc_ff.total_count <= acc_ff.total_count + TOTAL_W'(cur);
            if (cur < acc_ff.min_count) acc_ff.min_count <= cur;
            if (cur > acc_ff.max_count) acc_ff.max_count <= cur;
         end
      end
   end

endmodule

FILE: rtl/core/kswstat_queue.sv
module kswstat_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  kswstat_pkg::stat_item_type in_item,
   output logic                       out_valid,
   input  logic                       out_ready,
   output kswstat_pkg::stat_item_type out_item
);
   import kswstat_pkg::*;

   stat_item_type slot_ff [2];
   logic          wr_ff, rd_ff;
   logic [1:0]    cnt_ff;

   assign in_ready  = (cnt_ff != 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_item  = slot_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (in_valid && in_ready) wr_ff <= ~wr_ff;
         if (out_valid && out_ready) rd_ff <= ~rd_ff;
         cnt_ff <= cnt_ff + 2'(in_valid && in_ready) - 2'(out_valid && out_ready);
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) slot_ff[wr_ff] <= in_item;
   end

endmodule

FILE: rtl/core/kswstat_back.sv
module kswstat_back (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  kswstat_pkg::stat_item_type in_item,
   output logic                       out_valid,
   input  logic                       out_ready,
   output kswstat_pkg::stat_item_type out_item,
   output logic [31:0]                out_mean
);
   import kswstat_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0]         state_ff, state_in;
   stat_item_type      item_ff;
   logic [TOTAL_W-1:0] quo_ff;
   logic [LEN_W:0]     rem_ff;
   logic [5:0]         bit_ff;
   logic [LEN_W:0]     trial;
   logic               take;

   assign in_ready  = (state_ff == ST_IDLE);
   assign out_valid = (state_ff == ST_DONE);
   assign take      = in_valid && in_ready;
   assign out_item  = item_ff;
   assign out_mean  = (item_ff.depth == '0) ? '0 : quo_ff[31:0];
   assign trial     = {rem_ff[LEN_W-1:0], quo_ff[TOTAL_W-1]};

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (take) state_in = ST_DIV;
         ST_DIV:  if (bit_ff == 6'd0) state_in = ST_DONE;
         ST_DONE: if (out_ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   // restoring divide, one quotient bit a cycle
   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= in_item;
         quo_ff  <= in_item.total_count;
         rem_ff  <= '0;
         bit_ff  <= 6'(TOTAL_W - 1);
      end else if (state_ff == ST_DIV) begin
         bit_ff <= bit_ff - 6'd1;
         if (item_ff.depth != '0 && trial >= {1'b0, item_ff.depth}) begin
            rem_ff <= trial - {1'b0, item_ff.depth};
            quo_ff <= {quo_ff[TOTAL_W-2:0], 1'b1};
         end else begin
            rem_ff <= trial;
            quo_ff <= {quo_ff[TOTAL_W-2:0], 1'b0};
         end
      end
   end

endmodule

FILE: rtl/core/kmer_span_window_stats.sv
// Sliding-window k-mer count statistics. Each pushed item is one sequence
// position; one result per item comes out in order. The front scans the
// window one entry a cycle (window_length entries, clamped to 1 to 32) and
// takes no new item until its result is handed on; a two-entry queue
// follows, and the back finds the mean with a bit-serial restoring divider
// that likewise holds one item at a time. The divider is always the slower
// side, so in steady state it sets the rate at which the block takes items.
// Holding pop low stalls the back, then the queue fills and the front stops
// accepting. csr writes set window_length and belong only in idle periods.
module kmer_span_window_stats (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   output logic         full,
   input  logic [31:0]  req_kmer_count,
   input  logic         req_seq_start,
   input  logic         req_seq_end,
   output logic         empty,
   input  logic         pop,
   output logic [31:0]  rsp_count_here,
   output logic [5:0]   rsp_depth,
   output logic [31:0]  rsp_min_count,
   output logic [31:0]  rsp_max_count,
   output logic [31:0]  rsp_mean_count,
   output logic [36:0]  rsp_total_count,
   output logic         rsp_last_of_sequence,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [5:0]   csr_window_length
);
   import kswstat_pkg::*;

   logic [5:0]    window_length_ff;
   req_item_type  req_item;
   stat_item_type f_item, q_item, b_item;
   logic          f_valid, f_ready, q_valid, q_ready, in_ready, out_valid;

   assign csr_ready = 1'b1;
   assign full      = ~in_ready;
   assign empty     = ~out_valid;
   assign req_item  = '{kmer_count: req_kmer_count, seq_start: req_seq_start,
                        seq_end: req_seq_end};

   always_ff @(posedge clock) begin
      if (reset) window_length_ff <= 6'd22;
      else if (csr_valid) window_length_ff <= csr_window_length;
   end

   kswstat_front u_front (
      .clock, .reset, .in_valid(push), .in_ready(in_ready), .in_item(req_item),
      .window_length(window_length_ff), .out_valid(f_valid), .out_ready(f_ready),
      .out_item(f_item)
   );

   kswstat_queue u_queue (
      .clock, .reset, .in_valid(f_valid), .in_ready(f_ready), .in_item(f_item),
      .out_valid(q_valid), .out_ready(q_ready), .out_item(q_item)
   );

   kswstat_back u_back (
      .clock, .reset, .in_valid(q_valid), .in_ready(q_ready), .in_item(q_item),
      .out_valid(out_valid), .out_ready(pop), .out_item(b_item),
      .out_mean(rsp_mean_count)
   );

   assign rsp_count_here       = b_item.count_here;
   assign rsp_depth            = b_item.depth;
   assign rsp_min_count        = b_item.min_count;
   assign rsp_max_count        = b_item.max_count;
   assign rsp_total_count      = b_item.total_count;
   assign rsp_last_of_sequence = b_item.last_of_sequence;

endmodule

FILE: sim/tb_kmer_span_window_stats.sv
module tb_kmer_span_window_stats;
   import kswstat_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int N_RANDOM = 1500;
   localparam int DRAIN_CYCLES = 120;

   typedef struct {
      logic [31:0] kmer_count;
      logic        seq_start;
      logic        seq_end;
      logic        has_expect;
      logic [5:0]  depth;
      logic [31:0] min_count;
      logic [31:0] max_count;
      logic [36:0] total_count;
   } directed_row_type;

   typedef struct {
      logic [31:0] count_here;
      logic [5:0]  depth;
      logic [31:0] min_count;
      logic [31:0] max_count;
      logic [31:0] mean_count;
      logic [36:0] total_count;
      logic        last_of_sequence;
   } span_stats_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        push = 1'b0;
   logic        full;
   logic [31:0] req_kmer_count = '0;
   logic        req_seq_start = 1'b0;
   logic        req_seq_end = 1'b0;
   logic        empty;
   logic        pop = 1'b0;
   logic [31:0] rsp_count_here;
   logic [5:0]  rsp_depth;
   logic [31:0] rsp_min_count;
   logic [31:0] rsp_max_count;
   logic [31:0] rsp_mean_count;
   logic [36:0] rsp_total_count;
   logic        rsp_last_of_sequence;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [5:0]  csr_window_length = '0;

   logic [5:0]     kmer_len_reg;
   logic [31:0]    span_counts [32];
   span_stats_type pending_stats [$];
   int             error_count = 0;
   int             idle_cycles = 0;
   bit             stim_done = 1'b0;

   kmer_span_window_stats i_dut (.*);

   always #4 clock = ~clock;

   function automatic span_stats_type predict_span(logic [31:0] cnt, logic start,
                                                   logic last);
      span_stats_type s;
      int             len;
      logic [31:0]    c;
      len = (kmer_len_reg == 0) ? 1 : ((kmer_len_reg > 32) ? 32 : int'(kmer_len_reg));
      if (start) begin
         foreach (span_counts[i]) span_counts[i] = '0;
      end
      for (int i = 31; i > 0; i--) span_counts[i] = span_counts[i-1];
      span_counts[0] = cnt;
      s.count_here = cnt;
      s.depth = '0;
      s.min_count = 32'hFFFF_FFFF;
      s.max_count = '0;
      s.total_count = '0;
      s.last_of_sequence = last;
      for (int i = 0; i < len; i++) begin
         c = span_counts[i];
         if (c != 0) begin
            s.depth++;
            s.total_count += 37'(c);
            if (c < s.min_count) s.min_count = c;
            if (c > s.max_count) s.max_count = c;
         end
      end
      if (s.depth == 0) begin
         s.min_count = '0;
         s.mean_count = '0;
      end else begin
         s.mean_count = 32'(s.total_count / 37'(s.depth));
      end
      return s;
   endfunction

   task automatic send_item(logic [31:0] cnt, logic start, logic last);
      span_stats_type s;
      repeat ($urandom_range(0, 7)) begin
         @(negedge clock);
         push <= 1'b0;
      end
      @(negedge clock);
      push <= 1'b1;
      req_kmer_count <= cnt;
      req_seq_start <= start;
      req_seq_end <= last;
      do @(posedge clock); while (full);
      s = predict_span(cnt, start, last);
      pending_stats.push_back(s);
      @(negedge clock);
      push <= 1'b0;
   endtask

   task automatic wait_drained();
      while (pending_stats.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_kmer_len(logic [5:0] len);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_window_length <= len;
      do @(posedge clock); while (!csr_ready);
      kmer_len_reg = len;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic check_field(string name, logic [36:0] exp_v, logic [36:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s: expected %0h, actual %0h", name, exp_v, act_v);
         error_count++;
      end
   endtask

   // result side
   initial begin
      int             wait_n;
      span_stats_type e;
      wait_n = 0;
      forever begin
         @(negedge clock);
         if (wait_n > 0) begin
            pop <= 1'b0;
            wait_n--;
         end else begin
            pop <= 1'b1;
         end
         @(posedge clock);
         if (pop && !empty && !reset) begin
            wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
            if (pending_stats.size() == 0) begin
               $error("unexpected item: count_here %0h", rsp_count_here);
               error_count++;
            end else begin
               e = pending_stats.pop_front();
               check_field("count_here", e.count_here, rsp_count_here);
               check_field("depth", e.depth, rsp_depth);
               check_field("min_count", e.min_count, rsp_min_count);
               check_field("max_count", e.max_count, rsp_max_count);
               check_field("mean_count", e.mean_count, rsp_mean_count);
               check_field("total_count", e.total_count, rsp_total_count);
               check_field("last_of_sequence", e.last_of_sequence,
                           rsp_last_of_sequence);
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((push && !full) || (pop && !empty) || reset || stim_done)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      directed_row_type rows [$];
      span_stats_type   e;
      logic [5:0]       lens [5];
      logic [31:0]      c;
      int               mode;

      foreach (span_counts[i]) span_counts[i] = '0;
      kmer_len_reg = 6'd22;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // after reset, window 22
      rows.push_back('{32'd0, 1'b0, 1'b0, 1'b1, 6'd0, 32'd0, 32'd0, 37'd0});
      rows.push_back('{32'd5, 1'b0, 1'b0, 1'b1, 6'd1, 32'd5, 32'd5, 37'd5});
      rows.push_back('{32'hFFFF_FFFF, 1'b0, 1'b0, 1'b1, 6'd2, 32'd5, 32'hFFFF_FFFF,
                       37'h1_0000_0004});
      rows.push_back('{32'd1, 1'b0, 1'b1, 1'b0, '0, '0, '0, '0});
      rows.push_back('{32'd7, 1'b1, 1'b0, 1'b1, 6'd1, 32'd7, 32'd7, 37'd7});
      rows.push_back('{32'd0, 1'b1, 1'b1, 1'b1, 6'd0, 32'd0, 32'd0, 37'd0});
      for (int i = 0; i < 8; i++)
         rows.push_back('{32'hFFFF_FFFF - i, 1'b0, 1'b0, 1'b0, '0, '0, '0, '0});
      foreach (rows[i]) begin
         send_item(rows[i].kmer_count, rows[i].seq_start, rows[i].seq_end);
         if (rows[i].has_expect) begin
            e = pending_stats[$];
            check_field("directed depth", rows[i].depth, e.depth);
            check_field("directed min_count", rows[i].min_count, e.min_count);
            check_field("directed max_count", rows[i].max_count, e.max_count);
            check_field("directed total_count", rows[i].total_count, e.total_count);
         end
      end
      wait_drained();

      // window length zero, above max, max, one, then five
      lens = '{6'd0, 6'd63, 6'd32, 6'd1, 6'd5};
      foreach (lens[k]) begin
         write_kmer_len(lens[k]);
         for (int i = 0; i < 40; i++)
            send_item((i % 3 == 0) ? 32'd0 : 32'hFFFF_FFFF, i == 0, i == 39);
         wait_drained();
      end

      for (int i = 0; i < N_RANDOM; i++) begin
         if (i % 200 == 0) begin
            wait_drained();
            write_kmer_len(6'($urandom_range(0, 63)));
         end
         mode = $urandom_range(0, 3);
         case (mode)
            0: c = 32'd0;
            1: c = $urandom_range(1, 20);
            2: c = 32'hFFFF_FFFF - $urandom_range(0, 3);
            default: c = $urandom();
         endcase
         send_item(c, $urandom_range(0, 15) == 0, $urandom_range(0, 15) == 0);
      end
      wait_drained();
      stim_done = 1'b1;
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
